// ===== rtl/tlwc_pkg.sv =====
// Shared types, constants and the byte classifier for the text line/word counter.
package tlwc_pkg;

  localparam int DEF_COUNT_BITS  = 48;
  localparam int DEF_COLUMN_BITS = 32;
  localparam int DEF_TAB_STOP    = 8;

  localparam int OUT_COUNT_BITS  = 48;
  localparam int OUT_COLUMN_BITS = 32;
  localparam int DATA_BITS       = 8;
  localparam int RESULT_BITS     = 2 * OUT_COUNT_BITS + OUT_COLUMN_BITS;

  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;

  typedef struct packed {
    logic eos;
    logic newline;
    logic line_end;
    logic tab;
    logic printable;
    logic space;
  } item_t;

  function automatic item_t classify(input logic eos, input logic [7:0] b);
    item_t it;
    it.eos       = eos;
    it.newline   = !eos && (b == CHAR_NL);
    it.line_end  = !eos && ((b == CHAR_NL) || (b == CHAR_CR) || (b == CHAR_FF));
    it.tab       = !eos && (b == CHAR_TAB);
    it.printable = !eos && (b >= CHAR_SPACE) && (b <= CHAR_TILDE);
    it.space     = (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_NL) ||
                   (b == CHAR_VT) || (b == CHAR_FF) || (b == CHAR_CR);
    return it;
  endfunction

endpackage

// ===== rtl/tlwc_front.sv =====
// Input side: accepts byte transactions and classifies them for the queue.
module tlwc_front (
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [tlwc_pkg::DATA_BITS-1:0] s_axis_tdata,
  input  logic                        s_axis_tuser,
  input  logic                        queue_full,
  output logic                        push,
  output tlwc_pkg::item_t             push_item
);
  import tlwc_pkg::*;

  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && !queue_full;
  assign push_item     = classify(s_axis_tuser, s_axis_tdata);

endmodule

// ===== rtl/tlwc_queue.sv =====
// Short queue of classified items between the front and back parts.
module tlwc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tlwc_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output tlwc_pkg::item_t head_item
);
  import tlwc_pkg::*;

  item_t                   mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;

  assign full       = (count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ===== rtl/tlwc_back.sv =====
// Execution side: counters, column tracking and the result register.
module tlwc_back #(
  parameter int COUNT_BITS  = tlwc_pkg::DEF_COUNT_BITS,
  parameter int COLUMN_BITS = tlwc_pkg::DEF_COLUMN_BITS,
  parameter int TAB_STOP    = tlwc_pkg::DEF_TAB_STOP
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          head_valid,
  input  tlwc_pkg::item_t               head_item,
  output logic                          pop,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tlwc_pkg::RESULT_BITS-1:0] m_axis_tdata
);
  import tlwc_pkg::*;

  localparam int PHASE_BITS = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam logic [COUNT_BITS-1:0]  CNT_MAX    = '1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX    = '1;
  localparam logic [PHASE_BITS-1:0]  PHASE_LAST = PHASE_BITS'(TAB_STOP - 1);
  localparam logic [PHASE_BITS:0]    STOP       = (PHASE_BITS+1)'(TAB_STOP);
  localparam logic [63:0] OUT_CNT_MAX = 64'((65'd1 << OUT_COUNT_BITS) - 65'd1);
  localparam logic [63:0] OUT_COL_MAX = 64'((65'd1 << OUT_COLUMN_BITS) - 65'd1);

  logic                   width_mode;
  logic [COUNT_BITS-1:0]  line_cnt, line_cnt_next;
  logic [COUNT_BITS-1:0]  word_cnt, word_cnt_next;
  logic [COLUMN_BITS-1:0] column, column_next;
  logic [COLUMN_BITS-1:0] widest, widest_next;
  logic [PHASE_BITS-1:0]  phase, phase_next;
  logic                   in_word, in_word_next;

  logic [COLUMN_BITS-1:0] widest_fold;
  logic [PHASE_BITS:0]    tab_step;
  logic [COLUMN_BITS:0]   tab_sum;
  logic [63:0]            line_wide, word_wide, widest_wide;
  logic [RESULT_BITS-1:0] result;

  assign pop         = head_valid && (!head_item.eos || !m_axis_tvalid || m_axis_tready);
  assign widest_fold = (column > widest) ? column : widest;
  assign tab_step    = STOP - {1'b0, phase};
  assign tab_sum     = {1'b0, column} + (COLUMN_BITS+1)'(tab_step);

  assign line_wide   = 64'(line_cnt);
  assign word_wide   = 64'(word_cnt);
  assign widest_wide = 64'(widest_fold);
  assign result = {
    (widest_wide > OUT_COL_MAX) ? OUT_COL_MAX[OUT_COLUMN_BITS-1:0]
                                : widest_wide[OUT_COLUMN_BITS-1:0],
    (word_wide > OUT_CNT_MAX) ? OUT_CNT_MAX[OUT_COUNT_BITS-1:0]
                              : word_wide[OUT_COUNT_BITS-1:0],
    (line_wide > OUT_CNT_MAX) ? OUT_CNT_MAX[OUT_COUNT_BITS-1:0]
                              : line_wide[OUT_COUNT_BITS-1:0]
  };

  always_comb begin
    line_cnt_next = line_cnt;
    word_cnt_next = word_cnt;
    column_next   = column;
    widest_next   = widest;
    phase_next    = phase;
    in_word_next  = in_word;
    if (pop) begin
      if (head_item.eos) begin
        line_cnt_next = '0;
        word_cnt_next = '0;
        column_next   = '0;
        widest_next   = '0;
        phase_next    = '0;
        in_word_next  = 1'b0;
      end else begin
        if (head_item.newline && (line_cnt != CNT_MAX)) begin
          line_cnt_next = line_cnt + 1'b1;
        end
        if (!head_item.space && !in_word && (word_cnt != CNT_MAX)) begin
          word_cnt_next = word_cnt + 1'b1;
        end
        in_word_next = !head_item.space;
        if (width_mode) begin
          if (head_item.line_end) begin
            widest_next = widest_fold;
            column_next = '0;
            phase_next  = '0;
          end else if (head_item.tab) begin
            column_next = tab_sum[COLUMN_BITS] ? COL_MAX : tab_sum[COLUMN_BITS-1:0];
            phase_next  = '0;
          end else if (head_item.printable) begin
            if (column != COL_MAX) begin
              column_next = column + 1'b1;
            end
            phase_next = (phase == PHASE_LAST) ? '0 : phase + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_mode    <= 1'b0;
      line_cnt      <= '0;
      word_cnt      <= '0;
      column        <= '0;
      widest        <= '0;
      phase         <= '0;
      in_word       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        width_mode <= cfg_wdata;
      end
      line_cnt <= line_cnt_next;
      word_cnt <= word_cnt_next;
      column   <= column_next;
      widest   <= widest_next;
      phase    <= phase_next;
      in_word  <= in_word_next;
      if (pop && head_item.eos) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.eos) begin
      m_axis_tdata <= result;
    end
  end

  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && head_item.eos) |=> (line_cnt == '0) && (word_cnt == '0) &&
                               (column == '0) && m_axis_tvalid)
    else $error("end of stream did not clear counters or raise result");

endmodule

// ===== rtl/text_line_word_counter_core.sv =====
// Top level of the text line/word counter: front, queue and back parts.
//
//  channel  | dir | tdata                                   | tuser
//  s_axis   | in  | [7:0] data_byte                         | func (1 = end of stream)
//  m_axis   | out | [47:0] line, [95:48] word, [127:96] max | -
//  cfg      | in  | cfg_wdata = width_mode, written on cfg_we | -
//
//  One byte transaction per cycle while s_axis_tready is high; each item is
//  written into a 4-entry queue when taken and popped by the back part from its head,
//  and an end-of-stream item raises m_axis_tvalid at the edge on which it is popped.
//  A waiting result holds the next end-of-stream item at the queue head; the
//  queue fills behind it (four entries) and then s_axis_tready drops.
//  rst is synchronous and clears counters, queue and width_mode.
module text_line_word_counter_core #(
  parameter int COUNT_BITS  = tlwc_pkg::DEF_COUNT_BITS,
  parameter int COLUMN_BITS = tlwc_pkg::DEF_COLUMN_BITS,
  parameter int TAB_STOP    = tlwc_pkg::DEF_TAB_STOP
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_wdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tlwc_pkg::DATA_BITS-1:0]   s_axis_tdata,  // data_byte
  input  logic                             s_axis_tuser,  // func
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [tlwc_pkg::RESULT_BITS-1:0] m_axis_tdata   // line_total, word_total, longest_line
);
  import tlwc_pkg::*;

  logic  push;
  item_t push_item;
  logic  queue_full;
  logic  pop;
  logic  head_valid;
  item_t head_item;

  tlwc_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .queue_full    (queue_full),
    .push          (push),
    .push_item     (push_item)
  );

  tlwc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  tlwc_back #(
    .COUNT_BITS  (COUNT_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .TAB_STOP    (TAB_STOP)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
